FILE: sv/mchc_pkg.sv
// ----------------------------------------------------------------------------
// mchc_pkg
// Shared types, codes and defaults of the multi-click and hold classifier.
// ----------------------------------------------------------------------------
package mchc_pkg;

  localparam int TIME_BITS_DEF = 48;
  localparam int WIN_BITS      = 24;
  localparam int COUNT_BITS    = 6;
  localparam int CODE_BITS     = 8;

  localparam logic [WIN_BITS-1:0] CLICK_WIN_RST = 24'd150000;
  localparam logic [WIN_BITS-1:0] MULTI_WIN_RST = 24'd400000;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = 6'd63;

  localparam logic [CODE_BITS-1:0] CODE_NONE     = 8'h00;
  localparam logic [CODE_BITS-1:0] CODE_CLICK    = 8'h80;
  localparam logic [CODE_BITS-1:0] CODE_HOLD_ON  = 8'hC0;
  localparam logic [CODE_BITS-1:0] CODE_HOLD_OFF = 8'h40;

  localparam logic [1:0] BTN_RELEASE = 2'd0;
  localparam logic [1:0] BTN_PRESS   = 2'd1;

  localparam logic REG_CLICK_WIN = 1'b0;
  localparam logic REG_MULTI_WIN = 1'b1;

  typedef struct packed {
    logic press;
    logic release_ev;
  } evt_kind_t;

endpackage

FILE: sv/mchc_front.sv
// ----------------------------------------------------------------------------
// mchc_front
// Input stage: takes events and decodes them into press and release kinds.
// ----------------------------------------------------------------------------
module mchc_front #(
  parameter int TIME_BITS = mchc_pkg::TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [TIME_BITS-1:0]  timestamp_us,
  input  logic                  is_button,
  input  logic [1:0]            button_value,
  output logic                  push,
  input  logic                  push_ready,
  output logic [TIME_BITS-1:0]  ev_time,
  output mchc_pkg::evt_kind_t   ev_kind
);

  logic stage_valid;

  assign in_ready = !stage_valid || push_ready;
  assign push     = stage_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ev_time            <= timestamp_us;
      ev_kind.press      <= is_button && (button_value == mchc_pkg::BTN_PRESS);
      ev_kind.release_ev <= is_button && (button_value == mchc_pkg::BTN_RELEASE);
    end
  end

endmodule

FILE: sv/mchc_queue.sv
// ----------------------------------------------------------------------------
// mchc_queue
// Two-entry request queue between the decode stage and the classifier.
// ----------------------------------------------------------------------------
module mchc_queue #(
  parameter int DW = mchc_pkg::TIME_BITS_DEF + 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          push_ready,
  input  logic [DW-1:0] push_data,
  output logic          pop_valid,
  input  logic          pop,
  output logic [DW-1:0] pop_data
);

  logic [DW-1:0] mem [2];
  logic          wptr;
  logic          rptr;
  logic [1:0]    count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_data   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wptr <= !wptr;
      if (do_pop) rptr <= !rptr;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count beyond depth");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd1) |-> (wptr != rptr))
    else $error("queue pointers disagree with count");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + 2'd1))
    else $error("queue push lost");
  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> (count == $past(count) - 2'd1))
    else $error("queue pop lost");

endmodule

FILE: sv/mchc_back.sv
// ----------------------------------------------------------------------------
// mchc_back
// Classifier: timing windows, press counting and the output code register.
// ----------------------------------------------------------------------------
module mchc_back #(
  parameter int TIME_BITS = mchc_pkg::TIME_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wen,
  input  logic                                cfg_idx,
  input  logic [mchc_pkg::WIN_BITS-1:0]       cfg_wdata,
  input  logic                                ev_valid,
  output logic                                ev_pop,
  input  logic [TIME_BITS-1:0]                ev_time,
  input  mchc_pkg::evt_kind_t                 ev_kind,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mchc_pkg::CODE_BITS-1:0]      trigger_code
);

  logic [mchc_pkg::WIN_BITS-1:0]   click_win;
  logic [mchc_pkg::WIN_BITS-1:0]   multi_win;
  logic [mchc_pkg::COUNT_BITS-1:0] press_count;
  logic [mchc_pkg::COUNT_BITS-1:0] press_count_next;
  logic [TIME_BITS-1:0]            last_press_time;
  logic [TIME_BITS-1:0]            last_press_time_next;
  logic                            tap_seen;
  logic                            tap_seen_next;
  logic                            hold_reported;
  logic                            hold_reported_next;
  logic [mchc_pkg::CODE_BITS-1:0]  held_code;
  logic [mchc_pkg::CODE_BITS-1:0]  held_code_next;
  logic [TIME_BITS-1:0]            delta;

  assign ev_pop       = ev_valid && (!out_valid || out_ready);
  assign trigger_code = held_code;

  always_comb begin
    press_count_next     = press_count;
    last_press_time_next = last_press_time;
    tap_seen_next        = tap_seen;
    hold_reported_next   = hold_reported;
    held_code_next       = held_code;
    if (ev_kind.press) begin
      last_press_time_next = ev_time;
      if (press_count != mchc_pkg::COUNT_MAX) press_count_next = press_count + 1'b1;
      held_code_next = mchc_pkg::CODE_NONE;
      tap_seen_next  = 1'b0;
    end
    delta = ev_time - last_press_time_next;
    if (press_count_next != '0) begin
      if (delta < TIME_BITS'(click_win)) begin
        if (ev_kind.release_ev) tap_seen_next = 1'b1;
      end else if (delta < TIME_BITS'(multi_win)) begin
        if (!tap_seen_next) begin
          if (!hold_reported_next) begin
            held_code_next     = mchc_pkg::CODE_HOLD_ON | {2'b00, press_count_next};
            hold_reported_next = 1'b1;
          end else begin
            held_code_next = mchc_pkg::CODE_NONE;
          end
          if (ev_kind.release_ev) begin
            held_code_next     = mchc_pkg::CODE_HOLD_OFF | {2'b00, press_count_next};
            press_count_next   = '0;
            hold_reported_next = 1'b0;
          end
        end
      end else begin
        if (tap_seen_next) begin
          held_code_next   = mchc_pkg::CODE_CLICK | {2'b00, press_count_next};
          tap_seen_next    = 1'b0;
          press_count_next = '0;
        end
        if (ev_kind.release_ev) begin
          held_code_next     = mchc_pkg::CODE_HOLD_OFF | {2'b00, press_count_next};
          press_count_next   = '0;
          hold_reported_next = 1'b0;
        end
      end
    end else begin
      held_code_next = mchc_pkg::CODE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      click_win <= mchc_pkg::CLICK_WIN_RST;
      multi_win <= mchc_pkg::MULTI_WIN_RST;
    end else if (cfg_wen) begin
      unique case (cfg_idx)
        mchc_pkg::REG_CLICK_WIN: click_win <= cfg_wdata;
        mchc_pkg::REG_MULTI_WIN: multi_win <= cfg_wdata;
        default:                 click_win <= click_win;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      press_count     <= '0;
      last_press_time <= '0;
      tap_seen        <= 1'b0;
      hold_reported   <= 1'b0;
      held_code       <= mchc_pkg::CODE_NONE;
    end else begin
      if (ev_pop) begin
        out_valid       <= 1'b1;
        press_count     <= press_count_next;
        last_press_time <= last_press_time_next;
        tap_seen        <= tap_seen_next;
        hold_reported   <= hold_reported_next;
        held_code       <= held_code_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_code_held: assert property (@(posedge clk) disable iff (rst)
    !ev_pop |=> $stable(held_code) && $stable(press_count))
    else $error("state moved without an event");
  a_none_when_idle: assert property (@(posedge clk) disable iff (rst)
    (ev_pop && press_count_next == '0 && !ev_kind.release_ev) |=>
    (held_code == mchc_pkg::CODE_NONE || held_code[7]))
    else $error("code without press count");
  a_hold_off_clears: assert property (@(posedge clk) disable iff (rst)
    (ev_pop && held_code_next[7:6] == 2'b01) |=> (press_count == '0 && !hold_reported))
    else $error("hold-off left state behind");

endmodule

FILE: sv/multi_click_hold_classifier_top.sv
// ----------------------------------------------------------------------------
// multi_click_hold_classifier_top
// Throughput: one event per cycle while out_ready does not stall the output,
// one result per event; set by the combinational window compare and state
// update in the classifier.
// Reset: synchronous; clears counts, flags, code and queue, loads the default
// click window (150000 us) and multi-click window (400000 us).
// ----------------------------------------------------------------------------
module multi_click_hold_classifier_top #(
  parameter int TIME_BITS = mchc_pkg::TIME_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wen,
  input  logic                             cfg_idx,
  input  logic [mchc_pkg::WIN_BITS-1:0]    cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [TIME_BITS-1:0]             timestamp_us,
  input  logic                             is_button,
  input  logic [1:0]                       button_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mchc_pkg::CODE_BITS-1:0]   trigger_code
);

  localparam int DW = TIME_BITS + $bits(mchc_pkg::evt_kind_t);

  logic                 push;
  logic                 push_ready;
  logic [TIME_BITS-1:0] f_time;
  mchc_pkg::evt_kind_t  f_kind;
  logic                 q_valid;
  logic                 q_pop;
  logic [DW-1:0]        q_data;
  logic [TIME_BITS-1:0] b_time;
  mchc_pkg::evt_kind_t  b_kind;

  assign b_time = q_data[DW-1 -: TIME_BITS];
  assign b_kind = q_data[$bits(mchc_pkg::evt_kind_t)-1:0];

  mchc_front #(.TIME_BITS(TIME_BITS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .timestamp_us (timestamp_us),
    .is_button    (is_button),
    .button_value (button_value),
    .push         (push),
    .push_ready   (push_ready),
    .ev_time      (f_time),
    .ev_kind      (f_kind)
  );

  mchc_queue #(.DW(DW)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_data  ({f_time, f_kind}),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  mchc_back #(.TIME_BITS(TIME_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .ev_valid     (q_valid),
    .ev_pop       (q_pop),
    .ev_time      (b_time),
    .ev_kind      (b_kind),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .trigger_code (trigger_code)
  );

endmodule
